// ===== rtl/imu_tilt_heading_angles_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tilt and heading angle block
// Shared property wrappers used by the top level.
// ----------------------------------------------------------------------------
`ifndef IMU_TILT_HEADING_ANGLES_TOP_DEFINES_SVH
`define IMU_TILT_HEADING_ANGLES_TOP_DEFINES_SVH

// Generic implication check with synchronous reset qualifier.
`define ITH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define ITH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ith_pkg.sv =====
// ----------------------------------------------------------------------------
// ith_pkg
// Constants, types and the arctangent table for the angle pipeline.
// ----------------------------------------------------------------------------
package ith_pkg;

  localparam int GuardBits    = 8;
  localparam int AtanEntries  = 24;
  localparam int ZW           = 26;      // angle accumulator, 2^-16 degree
  localparam int HalfRange    = 23040;
  localparam int QuarterRange = 11520;
  localparam int OutW         = 16;
  localparam int PitchW       = 15;
  localparam logic signed [ZW-1:0] Deg180Z = 26'sd11796480;

  function automatic logic [ZW-1:0] atan_q16(input int idx);
    logic [ZW-1:0] v;
    begin
      unique case (idx)
        0: v = 26'd2949120;  1: v = 26'd1740967;  2: v = 26'd919879;
        3: v = 26'd466945;   4: v = 26'd234379;   5: v = 26'd117304;
        6: v = 26'd58666;    7: v = 26'd29335;    8: v = 26'd14668;
        9: v = 26'd7334;     10: v = 26'd3667;    11: v = 26'd1833;
        12: v = 26'd917;     13: v = 26'd458;     14: v = 26'd229;
        15: v = 26'd115;     16: v = 26'd57;      17: v = 26'd29;
        18: v = 26'd14;      19: v = 26'd7;       20: v = 26'd4;
        21: v = 26'd2;       22: v = 26'd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/ith_if.sv =====
// ----------------------------------------------------------------------------
// ith_in_if / ith_out_if
// Valid/ready channels for sample beats and angle beats.
// ----------------------------------------------------------------------------
interface ith_in_if #(parameter int SW = 16);
  logic valid;
  logic ready;
  logic signed [SW-1:0] acc_x;
  logic signed [SW-1:0] acc_y;
  logic signed [SW-1:0] acc_z;
  logic signed [SW-1:0] mag_x;
  logic signed [SW-1:0] mag_y;
  modport source(output valid, acc_x, acc_y, acc_z, mag_x, mag_y, input ready);
  modport sink(input valid, acc_x, acc_y, acc_z, mag_x, mag_y, output ready);
endinterface

interface ith_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] heading;
  logic signed [14:0] pitch;
  logic signed [15:0] roll;
  modport source(output valid, heading, pitch, roll, input ready);
  modport sink(input valid, heading, pitch, roll, output ready);
endinterface

// ===== rtl/ith_isqrt.sv =====
// ----------------------------------------------------------------------------
// ith_isqrt
// Pipelined restoring square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ith_isqrt #(
  parameter int NW = 66,             // radicand width (even)
  parameter int TW = 1               // tag width carried alongside
) (
  input  logic              clk,
  input  logic              en,
  input  logic [NW-1:0]     rad,
  input  logic [TW-1:0]     tag_in,
  output logic [NW/2-1:0]   root,
  output logic [TW-1:0]     tag_out
);
  localparam int RW = NW / 2;
  logic [NW-1:0] rem_r  [0:RW];
  logic [RW-1:0] res_r  [0:RW];
  logic [NW-1:0] n_r    [0:RW];
  logic [TW-1:0] tag_r  [0:RW];

  always_comb begin
    rem_r[0] = '0;
    res_r[0] = '0;
    n_r[0]   = rad;
    tag_r[0] = tag_in;
  end

  // stage k brings down two radicand bits and decides one root bit;
  // trial subtrahend is 4*root + 1
  for (genvar k = 0; k < RW; k++) begin : g_st
    logic [NW+1:0] rem_sh;
    logic [NW+1:0] trial;
    always_comb begin
      rem_sh = {rem_r[k], n_r[k][NW-1 -: 2]};
      trial  = {{(NW-RW){1'b0}}, res_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1]   <= n_r[k] << 2;
        tag_r[k+1] <= tag_r[k];
        if (rem_sh >= trial) begin
          rem_r[k+1] <= NW'(rem_sh - trial);
          res_r[k+1] <= {res_r[k][RW-2:0], 1'b1};
        end else begin
          rem_r[k+1] <= NW'(rem_sh);
          res_r[k+1] <= {res_r[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root    = res_r[RW];
  assign tag_out = tag_r[RW];
endmodule

// ===== rtl/ith_cordic.sv =====
// ----------------------------------------------------------------------------
// ith_cordic
// Vectoring-mode CORDIC, one micro-rotation per register stage,
// with final rounding to 1/128 degree and saturation.
// ----------------------------------------------------------------------------
module ith_cordic #(
  parameter int VW     = 42,
  parameter int STAGES = 16,
  parameter int LIM    = 23040,
  parameter int OW     = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  output logic signed [OW-1:0] ang
);
  import ith_pkg::*;
  localparam int XW = VW + 2;

  logic signed [XW-1:0] x_r [0:STAGES];
  logic signed [XW-1:0] y_r [0:STAGES];
  logic signed [ZW-1:0] z_r [0:STAGES];
  logic                 zero_r [0:STAGES];

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -XW'(x_in);
        y_r[0] <= -XW'(y_in);
        z_r[0] <= (y_in >= 0) ? Deg180Z : -Deg180Z;
      end else begin
        x_r[0] <= XW'(x_in);
        y_r[0] <= XW'(y_in);
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] a;
    always_comb begin
      xs = x_r[i] >>> ((i < XW) ? i : XW - 1);
      ys = y_r[i] >>> ((i < XW) ? i : XW - 1);
      a  = signed'(atan_q16(i));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + a;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - a;
        end
      end
    end
  end

  // round to nearest, ties up, then clamp
  logic signed [ZW-1:0] zr;
  logic signed [ZW-9-1:0] q;
  always_comb begin
    zr = z_r[STAGES] + ZW'(256);
    q  = zr[ZW-1:9];
    if (zero_r[STAGES])                   ang = '0;
    else if (q > (ZW-9)'(LIM))            ang = OW'(LIM);
    else if (q < -(ZW-9)'(LIM))           ang = -OW'(LIM);
    else                                  ang = OW'(q);
  end
endmodule

// ===== rtl/imu_tilt_heading_angles_top.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_heading_angles_top
// Heading, pitch and roll from accelerometer and magnetometer samples.
// ----------------------------------------------------------------------------
// Pipeline: input register, square root stages, CORDIC pre-rotation and rotation stages, output register.
// Throughput: one beat per cycle while not stalled; the whole pipeline advances together.
// The pipe stalls only when the output register is full and not taken.
// Reset (rst_n, synchronous) clears valid bits only; data is not reset.
module imu_tilt_heading_angles_top #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst_n,
  ith_in_if.sink    in_ch,
  ith_out_if.source out_ch
);
  import ith_pkg::*;
  `include "imu_tilt_heading_angles_top_defines.svh"

  localparam int SW   = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
  localparam int VW   = SW + GuardBits + 1;       // scaled vectors
  localparam int SQW  = 2 * SW + 1;               // sum of squares
  localparam int NW0  = SQW + 2 * GuardBits;
  localparam int NW   = NW0 + (NW0 % 2);          // even radicand width
  localparam int RW   = NW / 2;                   // root width
  localparam int CVW  = (RW + 1 > VW) ? RW + 1 : VW;
  localparam int SQLAT = RW;
  localparam int LAT   = 1 + SQLAT + 1 + CORDIC_STAGES;
  localparam int TW    = 4 * SW;

  // Pipeline advance: the whole pipe moves when the output slot is free.
  logic en;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0: register the samples, square the accelerometer y/z and sum them.
  logic signed [SW-1:0] ax_r, ay_r, az_r, mx_r, my_r;
  logic [SQW-1:0] sumsq_r;
  logic signed [2*SW-1:0] sq_y, sq_z;
  always_comb begin
    sq_y = $signed(in_ch.acc_y[SW-1:0]) * $signed(in_ch.acc_y[SW-1:0]);
    sq_z = $signed(in_ch.acc_z[SW-1:0]) * $signed(in_ch.acc_z[SW-1:0]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r <= in_ch.acc_x[SW-1:0];
      ay_r <= in_ch.acc_y[SW-1:0];
      az_r <= in_ch.acc_z[SW-1:0];
      mx_r <= in_ch.mag_x[SW-1:0];
      my_r <= in_ch.mag_y[SW-1:0];
      sumsq_r <= SQW'($unsigned(sq_y)) + SQW'($unsigned(sq_z));
    end
  end

  // Square root stage; ax, ay, az and mx ride along as tag, my in its own delay line.
  logic [RW-1:0] mag;
  logic [TW-1:0] tag_o;
  ith_isqrt #(.NW(NW), .TW(TW)) u_sqrt (
    .clk(clk), .en(en),
    .rad({{(NW-NW0){1'b0}}, sumsq_r, {(2*GuardBits){1'b0}}}),
    .tag_in({ax_r, ay_r, az_r, mx_r}), .root(mag), .tag_out(tag_o)
  );
  logic signed [SW-1:0] my_d [0:SQLAT];
  assign my_d[0] = my_r;
  for (genvar k = 0; k < SQLAT; k++) begin : g_myd
    always_ff @(posedge clk) if (en) my_d[k+1] <= my_d[k];
  end

  // Build the three scaled vectors.
  logic signed [SW-1:0] tax, tay, taz, tmx;
  assign {tax, tay, taz, tmx} = tag_o;
  logic signed [CVW-1:0] hx, hy, px, py, rx, ry;
  always_comb begin
    hx = CVW'(tmx) <<< GuardBits;
    hy = CVW'(my_d[SQLAT]) <<< GuardBits;
    px = CVW'(signed'({1'b0, mag}));
    py = CVW'(tax) <<< GuardBits;
    rx = CVW'(taz) <<< GuardBits;
    ry = -(CVW'(tay) <<< GuardBits);
  end

  logic signed [OutW-1:0]   head_a, roll_a;
  logic signed [PitchW-1:0] pit_a;
  ith_cordic #(.VW(CVW), .STAGES(CORDIC_STAGES), .LIM(HalfRange), .OW(OutW)) u_head (
    .clk(clk), .en(en), .x_in(hx), .y_in(hy), .ang(head_a));
  ith_cordic #(.VW(CVW), .STAGES(CORDIC_STAGES), .LIM(QuarterRange), .OW(PitchW)) u_pit (
    .clk(clk), .en(en), .x_in(px), .y_in(py), .ang(pit_a));
  ith_cordic #(.VW(CVW), .STAGES(CORDIC_STAGES), .LIM(HalfRange), .OW(OutW)) u_roll (
    .clk(clk), .en(en), .x_in(rx), .y_in(ry), .ang(roll_a));

  // Valid shift line alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Output register: holds a beat until taken.
  logic signed [OutW-1:0]   head_r, roll_r;
  logic signed [PitchW-1:0] pit_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[LAT-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= head_a;
      pit_r  <= pit_a;
      roll_r <= roll_a;
    end
  end
  assign out_ch.valid   = out_vld_r;
  assign out_ch.heading = head_r;
  assign out_ch.pitch   = pit_r;
  assign out_ch.roll    = roll_r;

  // Checks
  `ITH_ASSERT_NEXT(a_hold, clk, rst_n, out_vld_r && !out_ch.ready, out_vld_r && $stable(head_r), "stalled beat changed")
  `ITH_ASSERT_IMPL(a_range, clk, rst_n, out_vld_r, head_r <= 16'sd23040 && head_r >= -16'sd23040, "heading out of range")
  `ITH_ASSERT_NEXT(a_adv, clk, rst_n, en && vld_r[LAT-1], out_vld_r, "beat lost at output")
endmodule

// ===== tb/ith_angle_checker.sv =====
// ----------------------------------------------------------------------------
// ith_angle_checker
// Watches the sample and angle channels, computes the expected heading,
// pitch and roll for every accepted sample beat and compares them in order.
// ----------------------------------------------------------------------------
module ith_angle_checker (
  input  logic clk,
  input  logic rst_n,
  ith_in_if    in_ch,
  ith_out_if   out_ch,
  output int   pending,
  output int   errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import ith_pkg::*;

  typedef struct {
    logic signed [15:0] heading;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  angles_t angle_q[$];

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // vectoring CORDIC, result in 1/128 degree before saturation
  function automatic longint vector_angle(input longint y, input longint x);
    longint z, xs, ys, a;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(Deg180Z) : -longint'(Deg180Z);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      a  = (i < AtanEntries) ? longint'(atan_q16(i)) : 0;
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + a;
      end else begin
        x = x - ys; y = y + xs; z = z - a;
      end
    end
    return (z + 256) >>> 9;
  endfunction

  function automatic longint sat(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic angles_t tilt_heading(input longint ax, ay, az, mx, my);
    angles_t r;
    longint unsigned mag;
    mag = int_sqrt(longint'(ay * ay + az * az) << 16);
    r.heading = 16'(sat(vector_angle(my * 256, mx * 256), HalfRange));
    r.pitch   = 15'(sat(vector_angle(ax * 256, longint'(mag)), QuarterRange));
    r.roll    = 16'(sat(vector_angle(-ay * 256, az * 256), HalfRange));
    return r;
  endfunction

  initial errors = 0;
  assign pending = angle_q.size();

  always @(posedge clk) begin
    angles_t want;
    if (rst_n && in_ch.valid && in_ch.ready)
      angle_q.push_back(tilt_heading(in_ch.acc_x, in_ch.acc_y, in_ch.acc_z,
                                     in_ch.mag_x, in_ch.mag_y));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (angle_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected angle beat h=%0d p=%0d r=%0d", $time,
                 out_ch.heading, out_ch.pitch, out_ch.roll);
      end else begin
        want = angle_q.pop_front();
        if (want.heading !== out_ch.heading) begin
          errors++;
          $display("%0t: heading expected %0d actual %0d", $time,
                   want.heading, out_ch.heading);
        end
        if (want.pitch !== out_ch.pitch) begin
          errors++;
          $display("%0t: pitch expected %0d actual %0d", $time,
                   want.pitch, out_ch.pitch);
        end
        if (want.roll !== out_ch.roll) begin
          errors++;
          $display("%0t: roll expected %0d actual %0d", $time,
                   want.roll, out_ch.roll);
        end
      end
    end
  end
endmodule

// ===== tb/tb_imu_tilt_heading_angles_top.sv =====
// ----------------------------------------------------------------------------
// tb_imu_tilt_heading_angles_top
// Drives sample beats into the angle pipeline with random gaps and output
// stalls, including one long output hold-off, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_imu_tilt_heading_angles_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1430;
  localparam int CalmTail  = 150;     // last beats sent with no idling
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 100;   // pipeline is ~44 deep

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   pending, errors;
  int   cycles = 0;
  int   sent = 0;
  int   extreme_beats = 0;
  bit   calm = 1'b0;
  bit   long_hold = 1'b0;

  ith_in_if #(.SW(16)) in_ch();
  ith_out_if           out_ch();

  imu_tilt_heading_angles_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  ith_angle_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .pending(pending), .errors(errors)
  );

  always #10 clk = ~clk;

  // global watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.acc_x = '0; in_ch.acc_y = '0; in_ch.acc_z = '0;
    in_ch.mag_x = '0; in_ch.mag_y = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stall bursts; one long hold-off lets the pipe fill
  // up and push back on the sample side.
  initial begin
    int n;
    repeat (12) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one beat and holds it until taken. Ready is looked at on the
  // falling edge so the check never races the pipeline's own update.
  task automatic send_samples(input logic [15:0] ax, ay, az, mx, my);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.acc_x <= ax; in_ch.acc_y <= ay; in_ch.acc_z <= az;
    in_ch.mag_x <= mx; in_ch.mag_y <= my;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  // Random field: mostly full range, some small and some rail values so
  // the near-zero and saturation corners get hit often.
  function automatic logic [15:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 16'($signed($urandom_range(0, 8)) - 4);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] f [5];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vectors, rails, negative x on both sides of y = 0
    send_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_samples(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_samples(16'h7fff, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
    send_samples(16'h8000, 16'h0000, 16'h0000, 16'hffff, 16'hffff);
    send_samples(16'h0001, 16'h0001, 16'hffff, 16'h8000, 16'h0000);
    send_samples(16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h8000);
    send_samples(16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'h7fff);
    send_samples(16'h0000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_samples(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_samples(16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000);
    send_samples(16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'h0001);
    send_samples(16'h4000, 16'h4000, 16'h4000, 16'hc000, 16'h4000);
    send_samples(16'hc000, 16'hc000, 16'hc000, 16'hc000, 16'hc000);
    send_samples(16'h0001, 16'h0000, 16'h0001, 16'h0001, 16'h0001);
    send_samples(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_samples(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_samples(16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff);

    for (int k = 0; k < NumRandom; k++) begin
      if (k == 200) long_hold = 1'b1;
      if (k == NumRandom - CalmTail) calm = 1'b1;
      foreach (f[j]) f[j] = rand_field();
      foreach (f[j]) if (f[j] == 16'h7fff || f[j] == 16'h8000) begin
        extreme_beats++;
        break;
      end
      send_samples(f[0], f[1], f[2], f[3], f[4]);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d sample beats (%0d with a rail value), random gaps", sent,
             extreme_beats);
    $display("and output stalls including one long hold-off; %0d cycles", cycles);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
